// ===== rtl/cfm_pkg.sv =====
// cfm_pkg: shared constants, codes and controller/datapath interface types
// for the capture frequency meter. No dependencies.

package cfm_pkg;

	// fixed field and register widths
	localparam int REF_W      = 25;
	localparam int AHB_W      = 4;
	localparam int APB_W      = 3;
	localparam int HZ_W       = 18;
	localparam int OP_W       = 2;
	localparam int CAPIN_W    = 16;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;

	// parameter defaults
	localparam int CAPTURES_DEF          = 16;
	localparam int EDGES_PER_CAPTURE_DEF = 8;
	localparam int ATTEMPTS_DEF          = 3;
	localparam int COUNTER_BITS_DEF      = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REF_CLK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AHB_CODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_APB2_CODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd5;

	// register reset values
	localparam logic [REF_W-1:0] REF_CLK_RST   = 25'd2097000;
	localparam logic [AHB_W-1:0] AHB_CODE_RST  = 4'd0;
	localparam logic [APB_W-1:0] APB2_CODE_RST = 3'd0;
	localparam logic [HZ_W-1:0]  NOMINAL_RST   = 18'd37000;
	localparam logic [HZ_W-1:0]  BAND_LOW_RST  = 18'd20000;
	localparam logic [HZ_W-1:0]  BAND_HIGH_RST = 18'd70000;

	// request operations
	localparam logic [OP_W-1:0] OP_START   = 2'd0;
	localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
	localparam logic [OP_W-1:0] OP_WRAP    = 2'd2;
	localparam logic [OP_W-1:0] OP_MISS    = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_MEASURED    = 2'd0;
	localparam logic [STAT_W-1:0] ST_OUT_OF_BAND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FAILED      = 2'd2;
	localparam logic [STAT_W-1:0] ST_CACHED      = 2'd3;

	// result source select
	localparam logic [1:0] SEL_CACHE    = 2'd0;
	localparam logic [1:0] SEL_NOMINAL  = 2'd1;
	localparam logic [1:0] SEL_MEASURED = 2'd2;

	typedef struct packed {
		logic              clr_sum;
		logic              load_prev;
		logic              acc_diff;
		logic              tclk_load;
		logic              num_load;
		logic              div_step;
		logic              out_load;
		logic [1:0]        out_sel;
		logic [STAT_W-1:0] out_status;
	} cfm_cmd_t;

	typedef struct packed {
		logic sum_zero;
		logic div_last;
		logic in_band;
	} cfm_stat_t;

endpackage

// ===== rtl/cfm_ctrl.sv =====
// cfm_ctrl: measurement sequencer, attempt/capture/wrap counters, cache flag
// and handshake control. Depends on cfm_pkg.

module cfm_ctrl #(
	parameter int CAPTURES = cfm_pkg::CAPTURES_DEF,
	parameter int ATTEMPTS = cfm_pkg::ATTEMPTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [cfm_pkg::OP_W-1:0]  operation,
	output logic                      out_valid,
	input  logic                      out_ready,
	output cfm_pkg::cfm_cmd_t         cmd,
	input  cfm_pkg::cfm_stat_t        stat
);
	import cfm_pkg::*;

	localparam int CAP_W = $clog2(CAPTURES + 1);
	localparam int ATT_W = $clog2(ATTEMPTS + 1);
	localparam logic [CAP_W-1:0] CAP_LAST = CAP_W'(CAPTURES - 1);
	localparam logic [ATT_W-1:0] ATT_LAST = ATT_W'(ATTEMPTS - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_SUM   = 3'd2;
	localparam logic [2:0] S_TCLK  = 3'd3;
	localparam logic [2:0] S_NUM   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_CHECK = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [CAP_W-1:0] cap_q, cap_d;
	logic             wrap_q, wrap_d;
	logic [ATT_W-1:0] att_q, att_d;
	logic             cvalid_q, cvalid_d;
	logic             out_valid_q;
	logic             accepting;
	logic             accept;
	logic             fail;
	logic             begin_att;

	assign accepting = (state_q == S_IDLE) || (state_q == S_FIRST) || (state_q == S_SUM);
	assign in_ready  = accepting && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		cap_d     = cap_q;
		wrap_d    = wrap_q;
		att_d     = att_q;
		cvalid_d  = cvalid_q;
		cmd       = '0;
		fail      = 1'b0;
		begin_att = 1'b0;
		case (state_q)
			S_IDLE, S_FIRST, S_SUM: begin
				if (accept) begin
					case (operation)
						OP_START: begin
							if (state_q == S_IDLE) begin
								if (cvalid_q) begin
									cmd.out_load   = 1'b1;
									cmd.out_sel    = SEL_CACHE;
									cmd.out_status = ST_CACHED;
								end else begin
									att_d     = '0;
									begin_att = 1'b1;
								end
							end
						end
						OP_CAPTURE: begin
							if (state_q != S_IDLE) begin
								wrap_d        = 1'b0;
								cmd.load_prev = 1'b1;
								if (state_q == S_FIRST) begin
									state_d = S_SUM;
								end else begin
									cmd.acc_diff = 1'b1;
									if (cap_q == CAP_LAST) begin
										state_d = S_TCLK;
									end else begin
										cap_d = cap_q + 1'b1;
									end
								end
							end
						end
						OP_WRAP: begin
							if (state_q != S_IDLE) begin
								if (wrap_q) begin
									fail = 1'b1;
								end else begin
									wrap_d = 1'b1;
								end
							end
						end
						default: begin
							if (state_q != S_IDLE) begin
								fail = 1'b1;
							end
						end
					endcase
				end
			end
			S_TCLK: begin
				if (stat.sum_zero) begin
					fail = 1'b1;
				end else begin
					cmd.tclk_load = 1'b1;
					state_d       = S_NUM;
				end
			end
			S_NUM: begin
				cmd.num_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.out_load = 1'b1;
				if (stat.in_band) begin
					cmd.out_sel    = SEL_MEASURED;
					cmd.out_status = ST_MEASURED;
				end else begin
					cmd.out_sel    = SEL_NOMINAL;
					cmd.out_status = ST_OUT_OF_BAND;
				end
				cvalid_d = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fail) begin
			if (att_q == ATT_LAST) begin
				cmd.out_load   = 1'b1;
				cmd.out_sel    = SEL_NOMINAL;
				cmd.out_status = ST_FAILED;
				cvalid_d       = 1'b1;
				state_d        = S_IDLE;
			end else begin
				att_d     = att_q + 1'b1;
				begin_att = 1'b1;
			end
		end

		if (begin_att) begin
			state_d     = S_FIRST;
			cmd.clr_sum = 1'b1;
			cap_d       = '0;
			wrap_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= '0;
			wrap_q      <= 1'b0;
			att_q       <= '0;
			cvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cap_q    <= cap_d;
			wrap_q   <= wrap_d;
			att_q    <= att_d;
			cvalid_q <= cvalid_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/cfm_dp.sv =====
// cfm_dp: configuration registers, capture difference accumulator, timer
// clock scaling, serial restoring divider and result registers.
// Depends on cfm_pkg.

module cfm_dp #(
	parameter int CAPTURES          = cfm_pkg::CAPTURES_DEF,
	parameter int EDGES_PER_CAPTURE = cfm_pkg::EDGES_PER_CAPTURE_DEF,
	parameter int COUNTER_BITS      = cfm_pkg::COUNTER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [cfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [cfm_pkg::CAPIN_W-1:0]     capture_count,
	input  cfm_pkg::cfm_cmd_t               cmd,
	output cfm_pkg::cfm_stat_t              stat,
	output logic [cfm_pkg::HZ_W-1:0]        frequency_hz,
	output logic [cfm_pkg::STAT_W-1:0]      result_status
);
	import cfm_pkg::*;

	localparam int EDGES  = EDGES_PER_CAPTURE * CAPTURES;
	localparam int EDGE_W = $clog2(EDGES + 1);
	localparam int SUM_W  = COUNTER_BITS + $clog2(CAPTURES);
	localparam int PROD_W = REF_W + EDGE_W;
	localparam int NUM_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
	localparam int DCNT_W = $clog2(NUM_W + 1);

	logic [REF_W-1:0]        ref_clk_q;
	logic [AHB_W-1:0]        ahb_code_q;
	logic [APB_W-1:0]        apb2_code_q;
	logic [HZ_W-1:0]         nominal_q;
	logic [HZ_W-1:0]         band_low_q;
	logic [HZ_W-1:0]         band_high_q;

	logic [COUNTER_BITS-1:0] prev_q;
	logic [COUNTER_BITS-1:0] cap_c;
	logic [COUNTER_BITS-1:0] diff;
	logic [SUM_W-1:0]        sum_q;

	logic [3:0]              ahb_shift;
	logic [1:0]              apb_shift;
	logic [REF_W-1:0]        tclk;
	logic [REF_W-1:0]        tclk_q;

	logic [NUM_W-1:0]        quo_q;
	logic [SUM_W-1:0]        rem_q;
	logic [SUM_W:0]          trial;
	logic                    trial_ge;
	logic [DCNT_W-1:0]       div_cnt_q;

	logic [HZ_W-1:0]         cache_q;
	logic [HZ_W-1:0]         freq_q;
	logic [STAT_W-1:0]       status_q;
	logic [HZ_W-1:0]         out_freq;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clk_q   <= REF_CLK_RST;
			ahb_code_q  <= AHB_CODE_RST;
			apb2_code_q <= APB2_CODE_RST;
			nominal_q   <= NOMINAL_RST;
			band_low_q  <= BAND_LOW_RST;
			band_high_q <= BAND_HIGH_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_REF_CLK:   ref_clk_q   <= cfg_data[REF_W-1:0];
				REG_AHB_CODE:  ahb_code_q  <= cfg_data[AHB_W-1:0];
				REG_APB2_CODE: apb2_code_q <= cfg_data[APB_W-1:0];
				REG_NOMINAL:   nominal_q   <= cfg_data[HZ_W-1:0];
				REG_BAND_LOW:  band_low_q  <= cfg_data[HZ_W-1:0];
				REG_BAND_HIGH: band_high_q <= cfg_data[HZ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// capture differences, wrapped to the counter width
	assign cap_c = COUNTER_BITS'(capture_count);
	assign diff  = cap_c - prev_q;

	always_ff @(posedge clk) begin
		if (cmd.load_prev) begin
			prev_q <= cap_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.clr_sum) begin
			sum_q <= '0;
		end else if (cmd.acc_diff) begin
			sum_q <= sum_q + SUM_W'(diff);
		end
	end

	// timer clock from the bus prescaler codes
	always_comb begin
		ahb_shift = 4'd0;
		if (ahb_code_q[3]) begin
			if (ahb_code_q[2]) begin
				ahb_shift = {2'b00, ahb_code_q[1:0]} + 4'd6;
			end else begin
				ahb_shift = {2'b00, ahb_code_q[1:0]} + 4'd1;
			end
		end
		apb_shift = apb2_code_q[2] ? apb2_code_q[1:0] : 2'd0;
		tclk      = (ref_clk_q >> ahb_shift) >> apb_shift;
	end

	always_ff @(posedge clk) begin
		if (cmd.tclk_load) begin
			tclk_q <= tclk;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial    = {rem_q, quo_q[NUM_W-1]};
	assign trial_ge = (trial >= {1'b0, sum_q});

	always_ff @(posedge clk) begin
		if (cmd.num_load) begin
			quo_q <= NUM_W'(tclk_q) * NUM_W'(EDGES) + NUM_W'(sum_q >> 1);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[NUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? SUM_W'(trial - {1'b0, sum_q}) : SUM_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.num_load) begin
			div_cnt_q <= DCNT_W'(NUM_W);
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	assign stat.sum_zero = (sum_q == '0);
	assign stat.div_last = (div_cnt_q == DCNT_W'(1));
	assign stat.in_band  = (quo_q >= NUM_W'(band_low_q)) && (quo_q <= NUM_W'(band_high_q));

	// result and cache
	always_comb begin
		case (cmd.out_sel)
			SEL_CACHE:    out_freq = cache_q;
			SEL_NOMINAL:  out_freq = nominal_q;
			SEL_MEASURED: out_freq = quo_q[HZ_W-1:0];
			default:      out_freq = nominal_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_q <= '0;
		end else if (cmd.out_load) begin
			cache_q <= out_freq;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			freq_q   <= out_freq;
			status_q <= cmd.out_status;
		end
	end

	assign frequency_hz  = freq_q;
	assign result_status = status_q;

endmodule

// ===== rtl/capture_frequency_meter_unit.sv =====
// capture_frequency_meter_unit: top level of the capture frequency meter,
// joining the sequencer (cfm_ctrl) and the datapath (cfm_dp). Uses cfm_pkg.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   in       | in_valid / in_ready      | operation, capture_count
//   out      | out_valid / out_ready    | frequency_hz, result_status
//   cfg      | cfg_write_en             | cfg_index, cfg_data
//
// Start, wrap, miss and non-final capture requests leave the meter ready
// for the next request. The final capture of an attempt starts the result
// computation: the timer clock is scaled, the dividend is formed, the serial
// divider forms the quotient a bit at a time (NUM_W bits, 34 at the defaults),
// and the band is checked, with no request accepted meanwhile.
// A request is taken only while the result register is empty or being read.
// Reset is asynchronous and needs no clearing pass.

module capture_frequency_meter_unit #(
	parameter int CAPTURES          = cfm_pkg::CAPTURES_DEF,
	parameter int EDGES_PER_CAPTURE = cfm_pkg::EDGES_PER_CAPTURE_DEF,
	parameter int ATTEMPTS          = cfm_pkg::ATTEMPTS_DEF,
	parameter int COUNTER_BITS      = cfm_pkg::COUNTER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [cfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cfm_pkg::OP_W-1:0]        operation,
	input  logic [cfm_pkg::CAPIN_W-1:0]     capture_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cfm_pkg::HZ_W-1:0]        frequency_hz,
	output logic [cfm_pkg::STAT_W-1:0]      result_status
);
	import cfm_pkg::*;

	cfm_cmd_t  cmd;
	cfm_stat_t stat;

	cfm_ctrl #(
		.CAPTURES (CAPTURES),
		.ATTEMPTS (ATTEMPTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	cfm_dp #(
		.CAPTURES          (CAPTURES),
		.EDGES_PER_CAPTURE (EDGES_PER_CAPTURE),
		.COUNTER_BITS      (COUNTER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.capture_count (capture_count),
		.cmd           (cmd),
		.stat          (stat),
		.frequency_hz  (frequency_hz),
		.result_status (result_status)
	);

endmodule

// ===== rtl/cfm_checker.sv =====
// cfm_port_checker: port-level checks for capture_frequency_meter_unit,
// attached by a bind statement at the end of this file. Depends on cfm_pkg.

module cfm_port_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [cfm_pkg::HZ_W-1:0]        frequency_hz,
	input logic [cfm_pkg::STAT_W-1:0]      result_status
);
	import cfm_pkg::*;

	// result held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(frequency_hz) && $stable(result_status))
		else $error("result changed while stalled");

	// no request taken while a result is stuck
	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request accepted while result register is full");

	// a measured value only comes out of the divider, never straight from a request
	a_measured_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && (result_status == ST_MEASURED) |-> $past(!(in_valid && in_ready)))
		else $error("measured result appeared right after a request");

endmodule

bind capture_frequency_meter_unit cfm_port_checker u_cfm_port_checker (.*);
